/* src/inference_request_dispatcher_core_assert.svh */
`ifndef INFERENCE_REQUEST_DISPATCHER_CORE_ASSERT_SVH
`define INFERENCE_REQUEST_DISPATCHER_CORE_ASSERT_SVH
// same-cycle implication, checked on clk, quiet during reset
`define IRD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dispatcher assertion failed");
// next-cycle implication, checked on clk, quiet during reset
`define IRD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dispatcher assertion failed");
`endif

/* src/ird_pkg.sv */
`timescale 1ns / 1ps
package ird_pkg;
	localparam int NUM_SLOTS_DEF = 256;
	localparam int NUM_GPUS_DEF  = 8;
	// divider widths: dividend covers depth*100 and the depth sum of 64 gpus
	localparam int DVW = 39;
	localparam int DSW = 8;

	localparam logic [1:0] OP_SUBMIT = 2'd0;
	localparam logic [1:0] OP_ASSIGN = 2'd1;
	localparam logic [1:0] OP_TELEM  = 2'd2;
	localparam logic [1:0] OP_REBAL  = 2'd3;

	localparam logic [1:0] STRAT_RR    = 2'd0;
	localparam logic [1:0] STRAT_LOAD  = 2'd1;
	localparam logic [1:0] STRAT_PERF  = 2'd2;
	localparam logic [1:0] STRAT_POWER = 2'd3;

	localparam logic [1:0] REG_STRATEGY  = 2'd0;
	localparam logic [1:0] REG_MAX_BATCH = 2'd1;
	localparam logic [1:0] REG_REBAL_PCT = 2'd2;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_INVALID   = 3'd1;
	localparam logic [2:0] STS_FULL      = 3'd2;
	localparam logic [2:0] STS_NOT_FOUND = 3'd3;
	localparam logic [2:0] STS_NO_GPU    = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] model_num;
		logic [8:0]  batch_len;
		logic [8:0]  priority_req;
		logic [31:0] req_id;
		logic [2:0]  gpu_sel;
		logic        gpu_available;
		logic [6:0]  mem_util_pct;
		logic [31:0] power_mw;
		logic [31:0] throughput;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] new_id;
		logic [2:0]  chosen_gpu;
		logic        rebalance_needed;
	} out_item_t;

	typedef enum logic [1:0] {
		ARITH_LOAD,
		ARITH_AVG,
		ARITH_LIM,
		ARITH_CHK
	} arith_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_PICK_START,
		S_PICK_GPU,
		S_PICK_DIVS,
		S_PICK_DIVW,
		S_COMMIT,
		S_BAL_SUM,
		S_BAL_AVGW,
		S_BAL_LMUL,
		S_BAL_CHK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic        load_item;
		logic        res_clr;
		logic        set_status;
		logic [2:0]  status_code;
		logic        do_submit;
		logic        tele_wr;
		logic        sidx_clr;
		logic        sidx_inc;
		logic        mem_rd;
		logic        gidx_clr;
		logic        gidx_inc;
		logic        rr_pick;
		logic        best_clr;
		logic        cand_upd;
		logic        depth_inc;
		logic        sum_clr;
		logic        sum_acc;
		logic        prod_ld;
		logic        div_start;
		arith_sel_t  arith_sel;
		logic        avg_ld;
		logic        chk;
		logic        out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] strat;
		logic       sub_bad;
		logic       table_full;
		logic       asg_bad;
		logic       sel_bad;
		logic       scan_end;
		logic       scan_hit;
		logic       gpu_end;
		logic       cnt_zero;
		logic       div_done;
	} dp_status_t;
endpackage

/* src/ird_divider.sv */
`timescale 1ns / 1ps
module ird_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [ird_pkg::DVW-1:0] dividend,
	input  logic [ird_pkg::DSW-1:0] divisor,
	output logic                    busy,
	output logic [ird_pkg::DVW-1:0] quotient
);
	import ird_pkg::*;

	localparam int CW = $clog2(DVW + 1);

	logic [DVW-1:0] q_q;
	logic [DSW:0]   r_q;
	logic [DSW-1:0] d_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [DSW:0]   shifted;
	logic           fits;

	// restoring division, one quotient bit per cycle
	assign shifted = {r_q[DSW-1:0], q_q[DVW-1]};
	assign fits    = shifted >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DVW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= fits ? (shifted - {1'b0, d_q}) : shifted;
			q_q <= {q_q[DVW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = q_q;
endmodule

/* src/ird_datapath.sv */
`timescale 1ns / 1ps
module ird_datapath #(
	parameter int NUM_SLOTS = ird_pkg::NUM_SLOTS_DEF,
	parameter int NUM_GPUS  = ird_pkg::NUM_GPUS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ird_pkg::in_item_t  in_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	input  ird_pkg::dp_cmd_t   cmd,
	output ird_pkg::dp_status_t sts,
	output ird_pkg::out_item_t out_data
);
	import ird_pkg::*;

	localparam int SAW = $clog2(NUM_SLOTS);
	localparam int FW  = $clog2(NUM_SLOTS + 1);
	localparam int GW  = $clog2(NUM_GPUS);
	localparam int GCW = $clog2(NUM_GPUS + 1);

	in_item_t       item_q;
	logic [1:0]     strategy_q;
	logic [8:0]     max_batch_q;
	logic [6:0]     reb_pct_q;
	logic [FW-1:0]  fill_q;
	logic [FW-1:0]  sidx_q;
	logic [31:0]    next_id_q;
	logic [GW-1:0]  rr_q;
	logic [GCW-1:0] gidx_q;
	logic [31:0]    slot_mem [NUM_SLOTS];
	logic [31:0]    rd_s1;

	logic [31:0]    depth_q [NUM_GPUS];
	logic           avail_q [NUM_GPUS];
	logic [6:0]     util_q  [NUM_GPUS];
	logic [31:0]    power_q [NUM_GPUS];
	logic [31:0]    perf_q  [NUM_GPUS];

	logic [GW-1:0]  best_q;
	logic [DVW-1:0] best_val_q;
	logic           found_q;
	logic [DVW-1:0] sum_q;
	logic [DSW-1:0] cnt_q;
	logic [31:0]    avg_q;
	logic [DVW-1:0] prod_s1;

	logic [2:0]     res_status_q;
	logic [31:0]    res_new_id_q;
	logic [2:0]     res_gpu_q;
	logic           res_need_q;
	out_item_t      out_q;

	logic [GW-1:0]  gi;
	logic [GW-1:0]  sel_idx;
	logic [31:0]    d_cur;
	logic [31:0]    mul_a;
	logic [6:0]     mul_b;
	logic [DVW-1:0] prod_c;
	logic [DVW-1:0] div_dvd;
	logic [DSW-1:0] div_dvs;
	logic           div_busy;
	logic [DVW-1:0] div_q;
	logic [DVW-1:0] cand_v;
	logic           better;
	logic [31:0]    diff;
	logic [31:0]    next_id_inc;

	assign gi      = gidx_q[GW-1:0];
	assign sel_idx = GW'(item_q.gpu_sel);
	assign d_cur   = depth_q[gi];

	// shared multiplier: depth*100 for load, avg*pct for the threshold, diff*100 for the check
	always_comb begin
		if (cmd.arith_sel == ARITH_LIM) begin
			mul_a = avg_q;
			mul_b = reb_pct_q;
		end else if (cmd.arith_sel == ARITH_CHK) begin
			mul_a = diff;
			mul_b = 7'd100;
		end else begin
			mul_a = d_cur;
			mul_b = 7'd100;
		end
	end
	assign prod_c = {7'b0, mul_a} * {32'b0, mul_b};

	always_comb begin
		unique case (cmd.arith_sel)
			ARITH_AVG: begin
				div_dvd = sum_q;
				div_dvs = cnt_q;
			end
			default: begin
				div_dvd = prod_s1;
				div_dvs = {1'b0, util_q[gi]} + DSW'(1);
			end
		endcase
	end

	ird_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_q)
	);

	always_comb begin
		case (strategy_q)
			STRAT_PERF:  cand_v = {7'b0, perf_q[gi]};
			STRAT_POWER: cand_v = {7'b0, power_q[gi]};
			default:     cand_v = div_q;
		endcase
		if (!found_q)                      better = 1'b1;
		else if (strategy_q == STRAT_PERF) better = cand_v > best_val_q;
		else                               better = cand_v < best_val_q;
	end

	assign diff        = (d_cur > avg_q) ? (d_cur - avg_q) : (avg_q - d_cur);
	assign next_id_inc = next_id_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q  <= STRAT_LOAD;
			max_batch_q <= 9'd64;
			reb_pct_q   <= 7'd30;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRATEGY:  strategy_q  <= cfg_data[1:0];
				REG_MAX_BATCH: max_batch_q <= cfg_data;
				REG_REBAL_PCT: reb_pct_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			next_id_q <= 32'd1;
			rr_q      <= '0;
			sidx_q    <= '0;
			gidx_q    <= '0;
			for (int g = 0; g < NUM_GPUS; g++) begin
				depth_q[g] <= '0;
				avail_q[g] <= 1'b1;
				util_q[g]  <= '0;
				power_q[g] <= '0;
				perf_q[g]  <= '0;
			end
		end else begin
			if (cmd.do_submit) begin
				fill_q    <= fill_q + 1'b1;
				next_id_q <= (next_id_inc == 32'd0) ? 32'd1 : next_id_inc;
			end
			if (cmd.rr_pick) rr_q <= (rr_q == GW'(NUM_GPUS - 1)) ? '0 : rr_q + 1'b1;
			if (cmd.sidx_clr)      sidx_q <= '0;
			else if (cmd.sidx_inc) sidx_q <= sidx_q + 1'b1;
			if (cmd.gidx_clr)      gidx_q <= '0;
			else if (cmd.gidx_inc) gidx_q <= gidx_q + 1'b1;
			if (cmd.depth_inc && depth_q[best_q] != 32'hFFFF_FFFF)
				depth_q[best_q] <= depth_q[best_q] + 32'd1;
			if (cmd.tele_wr) begin
				avail_q[sel_idx] <= item_q.gpu_available;
				util_q[sel_idx]  <= item_q.mem_util_pct;
				power_q[sel_idx] <= item_q.power_mw;
				perf_q[sel_idx]  <= item_q.throughput;
			end
		end
	end

	// request id store; the scan reads one slot, compares it, then reads the next
	always_ff @(posedge clk) begin
		if (cmd.do_submit) slot_mem[fill_q[SAW-1:0]] <= next_id_q;
		if (cmd.mem_rd)    rd_s1 <= slot_mem[sidx_q[SAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= in_data;
		if (cmd.rr_pick)   best_q <= rr_q;
		if (cmd.best_clr) begin
			best_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.cand_upd && avail_q[gi] && better) begin
			best_q     <= gi;
			best_val_q <= cand_v;
			found_q    <= 1'b1;
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.sum_acc && avail_q[gi]) begin
			sum_q <= sum_q + {7'b0, d_cur};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.prod_ld) prod_s1 <= prod_c;
		if (cmd.avg_ld)  avg_q   <= div_q[31:0];
		if (cmd.set_status)   res_status_q <= cmd.status_code;
		else if (cmd.res_clr) res_status_q <= STS_OK;
		if (cmd.do_submit)    res_new_id_q <= next_id_q;
		else if (cmd.res_clr) res_new_id_q <= '0;
		if (cmd.depth_inc)    res_gpu_q    <= 3'(best_q);
		else if (cmd.res_clr) res_gpu_q    <= '0;
		// diff beyond avg*pct/100 (truncated) is the same as 100*diff above avg*pct
		if (cmd.chk && avail_q[gi] && prod_c > prod_s1) res_need_q <= 1'b1;
		else if (cmd.res_clr)                           res_need_q <= 1'b0;
		if (cmd.out_ld) begin
			out_q.status           <= res_status_q;
			out_q.new_id           <= res_new_id_q;
			out_q.chosen_gpu       <= res_gpu_q;
			out_q.rebalance_needed <= res_need_q;
		end
	end

	assign sts.op         = item_q.op;
	assign sts.strat      = strategy_q;
	assign sts.sub_bad    = (item_q.batch_len == 9'd0) || (item_q.batch_len > max_batch_q)
		|| (item_q.priority_req > 9'd255);
	assign sts.table_full = fill_q == FW'(NUM_SLOTS);
	assign sts.asg_bad    = (item_q.req_id == 32'd0) || (item_q.model_num == 32'd0);
	assign sts.sel_bad    = {29'b0, item_q.gpu_sel} >= 32'(NUM_GPUS);
	assign sts.scan_end   = sidx_q == fill_q;
	assign sts.scan_hit   = rd_s1 == item_q.req_id;
	assign sts.gpu_end    = gidx_q == GCW'(NUM_GPUS);
	assign sts.cnt_zero   = cnt_q == '0;
	assign sts.div_done   = !div_busy;

	assign out_data = out_q;
endmodule

/* src/ird_ctrl.sv */
`timescale 1ns / 1ps
`include "inference_request_dispatcher_core_assert.svh"
module ird_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  ird_pkg::dp_status_t sts,
	output ird_pkg::dp_cmd_t    cmd
);
	import ird_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_ld || (out_valid_q && out_stall);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.res_clr = 1'b1;
				state_d     = S_FINISH;
				unique case (sts.op)
					OP_SUBMIT: begin
						if (sts.sub_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = STS_INVALID;
						end else if (sts.table_full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = STS_FULL;
						end else begin
							cmd.do_submit = 1'b1;
						end
					end
					OP_ASSIGN: begin
						if (sts.asg_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = STS_INVALID;
						end else begin
							cmd.sidx_clr = 1'b1;
							state_d      = S_SCAN_RD;
						end
					end
					OP_TELEM: begin
						if (sts.sel_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = STS_INVALID;
						end else begin
							cmd.tele_wr = 1'b1;
						end
					end
					default: begin
						cmd.gidx_clr = 1'b1;
						cmd.sum_clr  = 1'b1;
						state_d      = S_BAL_SUM;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (sts.scan_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = STS_NOT_FOUND;
					state_d         = S_FINISH;
				end else begin
					cmd.mem_rd   = 1'b1;
					cmd.sidx_inc = 1'b1;
					state_d      = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				state_d = sts.scan_hit ? S_PICK_START : S_SCAN_RD;
			end
			S_PICK_START: begin
				if (sts.strat == STRAT_RR) begin
					cmd.rr_pick = 1'b1;
					state_d     = S_COMMIT;
				end else begin
					cmd.gidx_clr = 1'b1;
					cmd.best_clr = 1'b1;
					state_d      = S_PICK_GPU;
				end
			end
			S_PICK_GPU: begin
				cmd.arith_sel = ARITH_LOAD;
				if (sts.gpu_end) begin
					state_d = S_COMMIT;
				end else if (sts.strat == STRAT_LOAD) begin
					cmd.prod_ld = 1'b1;
					state_d     = S_PICK_DIVS;
				end else begin
					cmd.cand_upd = 1'b1;
					cmd.gidx_inc = 1'b1;
				end
			end
			S_PICK_DIVS: begin
				cmd.arith_sel = ARITH_LOAD;
				cmd.div_start = 1'b1;
				state_d       = S_PICK_DIVW;
			end
			S_PICK_DIVW: begin
				if (sts.div_done) begin
					cmd.cand_upd = 1'b1;
					cmd.gidx_inc = 1'b1;
					state_d      = S_PICK_GPU;
				end
			end
			S_COMMIT: begin
				cmd.depth_inc = 1'b1;
				state_d       = S_FINISH;
			end
			S_BAL_SUM: begin
				cmd.arith_sel = ARITH_AVG;
				if (!sts.gpu_end) begin
					cmd.sum_acc  = 1'b1;
					cmd.gidx_inc = 1'b1;
				end else if (sts.cnt_zero) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = STS_NO_GPU;
					state_d         = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_BAL_AVGW;
				end
			end
			S_BAL_AVGW: begin
				if (sts.div_done) begin
					cmd.avg_ld = 1'b1;
					state_d    = S_BAL_LMUL;
				end
			end
			S_BAL_LMUL: begin
				cmd.arith_sel = ARITH_LIM;
				cmd.prod_ld   = 1'b1;
				cmd.gidx_clr  = 1'b1;
				state_d       = S_BAL_CHK;
			end
			S_BAL_CHK: begin
				cmd.arith_sel = ARITH_CHK;
				if (sts.gpu_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.chk      = 1'b1;
					cmd.gidx_inc = 1'b1;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`IRD_ASSERT_NEXT(a_accept_decodes, accept, state_q == S_DECODE)
	`IRD_ASSERT_NEXT(a_finish_delivers, cmd.out_ld, out_valid_q && state_q == S_IDLE)
	`IRD_ASSERT_NEXT(a_div_runs, cmd.div_start, !sts.div_done)
endmodule

/* src/inference_request_dispatcher_core.sv */
// steps: submit and telemetry go from decode to result; assign reads and compares request
// slots until a hit, then picks round robin or walks the gpus (multiply and iterative 39-step
// divider for least loaded, a compare for throughput/power); rebalance sums, averages, checks
// throughput: one item at a time; the next transfer is taken once the result is registered
// reset: asynchronous, active low; clears ids, slots (fill count, no clearing pass),
// queue depths and telemetry; registers return to least loaded, batch 64, threshold 30
`timescale 1ns / 1ps
module inference_request_dispatcher_core #(
	parameter int NUM_SLOTS = ird_pkg::NUM_SLOTS_DEF,
	parameter int NUM_GPUS  = ird_pkg::NUM_GPUS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ird_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ird_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data
);
	import ird_pkg::*;

	// command and status between the sequencer and the datapath
	dp_cmd_t    cmd;
	dp_status_t sts;

	// sequencer: decodes the op, walks slots and gpus, drives the handshakes
	ird_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: id store, gpu state, shared multiplier and divider, result register
	ird_datapath #(
		.NUM_SLOTS (NUM_SLOTS),
		.NUM_GPUS  (NUM_GPUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
	import ird_pkg::*;

	localparam int SLOTS = 256;
	localparam int GPUS  = 8;
	localparam int IDLE_LIMIT = 200000;
	localparam int IN_W = $bits(in_item_t);
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;

	inference_request_dispatcher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirror of the dispatcher state
	logic [1:0]  m_strategy;
	logic [8:0]  m_max_batch;
	logic [6:0]  m_rebal_pct;
	logic [31:0] m_slot_id [SLOTS];
	logic        m_slot_used [SLOTS];
	logic [31:0] m_next_id;
	logic [2:0]  m_rr;
	logic [31:0] m_depth [GPUS];
	logic        m_avail [GPUS];
	logic [6:0]  m_util [GPUS];
	logic [31:0] m_power [GPUS];
	logic [31:0] m_perf [GPUS];

	out_item_t   expected_results [$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          hold_off = 1'b0;
	bit          burst_mode = 1'b1;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic logic [2:0] choose_gpu();
		logic [2:0] best;
		logic [63:0] best_val, v;
		bit found;
		bit better;
		best = '0;
		best_val = '0;
		found = 0;
		if (m_strategy == STRAT_RR) begin
			best = m_rr;
			m_rr = m_rr + 3'd1;
			return best;
		end
		for (int g = 0; g < GPUS; g++) begin
			if (!m_avail[g])
				continue;
			if (m_strategy == STRAT_LOAD)
				v = (64'(m_depth[g]) * 100) / (64'(m_util[g]) + 1);
			else if (m_strategy == STRAT_PERF)
				v = 64'(m_perf[g]);
			else
				v = 64'(m_power[g]);
			if (!found)
				better = 1;
			else if (m_strategy == STRAT_PERF)
				better = v > best_val;
			else
				better = v < best_val;
			if (better) begin
				best = g[2:0];
				best_val = v;
				found = 1;
			end
		end
		return best;
	endfunction

	function automatic out_item_t dispatch_result(input in_item_t it);
		out_item_t r;
		int i;
		logic [63:0] sum, cnt, avg, lim, d, diff;
		r = '0;
		case (it.op)
			OP_SUBMIT: begin
				if (it.batch_len == 0 || it.batch_len > m_max_batch
						|| it.priority_req > 255) begin
					r.status = STS_INVALID;
				end else begin
					for (i = 0; i < SLOTS && m_slot_used[i]; i++) ;
					if (i >= SLOTS) begin
						r.status = STS_FULL;
					end else begin
						m_slot_id[i] = m_next_id;
						m_slot_used[i] = 1;
						r.new_id = m_next_id;
						m_next_id = m_next_id + 32'd1;
						if (m_next_id == 32'd0)
							m_next_id = 32'd1;
					end
				end
			end
			OP_ASSIGN: begin
				if (it.req_id == 0 || it.model_num == 0) begin
					r.status = STS_INVALID;
				end else begin
					for (i = 0; i < SLOTS; i++)
						if (m_slot_used[i] && m_slot_id[i] == it.req_id)
							break;
					if (i >= SLOTS) begin
						r.status = STS_NOT_FOUND;
					end else begin
						r.chosen_gpu = choose_gpu();
						if (m_depth[r.chosen_gpu] != 32'hFFFF_FFFF)
							m_depth[r.chosen_gpu]++;
					end
				end
			end
			OP_TELEM: begin
				m_avail[it.gpu_sel] = it.gpu_available;
				m_util[it.gpu_sel] = it.mem_util_pct;
				m_power[it.gpu_sel] = it.power_mw;
				m_perf[it.gpu_sel] = it.throughput;
			end
			default: begin
				sum = 0;
				cnt = 0;
				for (i = 0; i < GPUS; i++)
					if (m_avail[i]) begin
						sum += 64'(m_depth[i]);
						cnt++;
					end
				if (cnt == 0) begin
					r.status = STS_NO_GPU;
				end else begin
					avg = sum / cnt;
					lim = (avg * 64'(m_rebal_pct)) / 100;
					for (i = 0; i < GPUS; i++) begin
						if (!m_avail[i])
							continue;
						d = 64'(m_depth[i]);
						diff = (d > avg) ? d - avg : avg - d;
						if (diff > lim) begin
							r.rebalance_needed = 1'b1;
							break;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	// result checker: compares each transfer on the output with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", out_data.new_id, 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.new_id !== want.new_id)
					report_mismatch("new_id", out_data.new_id, want.new_id);
				if (out_data.chosen_gpu !== want.chosen_gpu)
					report_mismatch("chosen_gpu", 32'(out_data.chosen_gpu),
						32'(want.chosen_gpu));
				if (out_data.rebalance_needed !== want.rebalance_needed)
					report_mismatch("rebalance_needed", 32'(out_data.rebalance_needed),
						32'(want.rebalance_needed));
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_off)
			out_stall <= 1'b1;
		else if (burst_mode)
			out_stall <= 1'b0;
		else
			out_stall <= (r < 30);
	end

	// watchdog: cycles without any transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	int gap_left = 0;

	// one transfer into the block, gaps between random bursts; valid stays up for the next
	task automatic send_item(input in_item_t it);
		if (gap_left == 0 && !burst_mode && $urandom_range(0, 5) == 0)
			gap_left = $urandom_range(1, 12);
		while (gap_left > 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(dispatch_result(it));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	// register write, only while nothing is in flight
	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_STRATEGY:  m_strategy = val[1:0];
			REG_MAX_BATCH: m_max_batch = val;
			REG_REBAL_PCT: m_rebal_pct = val[6:0];
			default: ;
		endcase
	endtask

	function automatic in_item_t random_item(input logic [1:0] op);
		in_item_t it;
		it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.op = op;
		return it;
	endfunction

	function automatic in_item_t make_submit(input int batch, input int prio);
		in_item_t it;
		it = random_item(OP_SUBMIT);
		it.batch_len = 9'(batch);
		it.priority_req = 9'(prio);
		return it;
	endfunction

	function automatic in_item_t make_assign(input logic [31:0] rid);
		in_item_t it;
		it = random_item(OP_ASSIGN);
		it.req_id = rid;
		if (it.model_num == 0)
			it.model_num = 32'd1;
		return it;
	endfunction

	function automatic in_item_t make_telem(input int g, input bit av, input int util,
			input logic [31:0] pw, input logic [31:0] tp);
		in_item_t it;
		it = random_item(OP_TELEM);
		it.gpu_sel = 3'(g);
		it.gpu_available = av;
		it.mem_util_pct = 7'(util);
		it.power_mw = pw;
		it.throughput = tp;
		return it;
	endfunction

	// a random item biased towards valid submits and live request ids
	function automatic in_item_t stimulus_item();
		in_item_t it;
		int k;
		k = $urandom_range(0, 99);
		if (k < 25) begin
			it = make_submit($urandom_range(1, m_max_batch), $urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0)
				it = random_item(OP_SUBMIT);
		end else if (k < 65) begin
			it = make_assign((m_next_id > 1) ? $urandom_range(1, m_next_id) : 32'd1);
			if ($urandom_range(0, 14) == 0)
				it = random_item(OP_ASSIGN);
			if ($urandom_range(0, 19) == 0)
				it.model_num = 32'd0;
		end else if (k < 85) begin
			it = make_telem($urandom_range(0, 7), $urandom_range(0, 3) != 0,
				$urandom_range(0, 100), $urandom_range(0, 9) ? $urandom_range(0, 50) :
				$urandom, $urandom_range(0, 9) ? $urandom_range(0, 50) : $urandom);
		end else begin
			it = random_item(OP_REBAL);
		end
		return it;
	endfunction

	task automatic reset_block();
		m_strategy = STRAT_LOAD;
		m_max_batch = 9'd64;
		m_rebal_pct = 7'd30;
		m_next_id = 32'd1;
		m_rr = '0;
		for (int i = 0; i < SLOTS; i++) begin
			m_slot_used[i] = 0;
			m_slot_id[i] = '0;
		end
		for (int g = 0; g < GPUS; g++) begin
			m_depth[g] = '0;
			m_avail[g] = 1;
			m_util[g] = '0;
			m_power[g] = '0;
			m_perf[g] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// field extremes, rejects and each strategy on a tiny table
	task automatic test_directed();
		send_item(make_telem(0, 0, 0, 0, 0));
		send_item(make_assign(1));
		send_item(make_submit(0, 0));
		send_item(make_submit(65, 0));
		send_item(make_submit(64, 256));
		send_item(make_submit(511, 511));
		send_item(make_submit(1, 255));
		send_item(make_submit(64, 0));
		send_item(make_assign(0));
		send_item(make_assign(32'hFFFF_FFFF));
		send_item(make_assign(1));
		send_item(make_telem(3, 1, 100, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_telem(7, 1, 127, 5, 5));
		send_item(make_assign(2));
		send_item(random_item(OP_REBAL));
		for (int g = 0; g < GPUS; g++)
			send_item(make_telem(g, 0, 0, 0, 0));
		send_item(make_assign(1));
		send_item(random_item(OP_REBAL));
		drain();
		for (int s = 0; s < 4; s++) begin
			write_reg(REG_STRATEGY, 9'(s));
			send_item(make_assign(2));
			send_item(make_assign(1));
			drain();
		end
	endtask

	// walks register settings, with random traffic under each
	task automatic test_random();
		logic [8:0] batches [4] = '{9'd1, 9'd256, 9'd511, 9'd64};
		logic [6:0] pcts [4] = '{7'd0, 7'd100, 7'd127, 7'd30};
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(REG_STRATEGY, 9'(phase % 4));
			write_reg(REG_MAX_BATCH, batches[phase % 4]);
			write_reg(REG_REBAL_PCT, 9'(pcts[(phase / 2) % 4]));
			write_reg(REG_SPARE, 9'($urandom));
			burst_mode = (phase == 0);
			for (int n = 0; n < 130; n++)
				send_item(stimulus_item());
			drain();
		end
	endtask

	// receiver holds off long enough that the block stalls its input
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int n = 0; n < 20; n++)
				send_item(stimulus_item());
		join
		drain();
	endtask

	// fills the slot table so later submits report table full
	task automatic test_table_full();
		write_reg(REG_MAX_BATCH, 9'd256);
		for (int n = 0; n < SLOTS + 8; n++)
			send_item(make_submit($urandom_range(1, 256), $urandom_range(0, 255)));
		for (int n = 0; n < 40; n++)
			send_item(stimulus_item());
		drain();
	endtask

	initial begin
		reset_block();
		test_directed();
		test_random();
		test_backpressure();
		test_table_full();
		drain();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

/* sim.f */
+incdir+src
src/ird_pkg.sv
src/ird_divider.sv
src/ird_datapath.sv
src/ird_ctrl.sv
src/inference_request_dispatcher_core.sv
dv/tb.sv
